FILE: hw/rtl/partitioned_sparse_set_table_unit_defines.svh
// Assertion macros shared by the partitioned sparse-set table RTL.
// Needs no other file. Simulation gets the checks; synthesis gets empty bodies.
`ifndef PARTITIONED_SPARSE_SET_TABLE_UNIT_DEFINES_SVH
`define PARTITIONED_SPARSE_SET_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check that is switched off while reset is asserted.
`define PSST_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("psst check failed");
// Check that also holds across reset.
`define PSST_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("psst reset check failed");
`else
`define PSST_ASSERT(lbl, clk, rstn, prop)
`define PSST_ASSERT_RST(lbl, clk, prop)
`endif

`endif

FILE: hw/rtl/psst_pkg.sv
// Types, constants and codes of the partitioned sparse-set table.
// Depends on nothing; used by partitioned_sparse_set_table_unit.
package psst_pkg;

    localparam int ENTITY_LIMIT  = 1024;
    localparam int SLOT_CAPACITY = 1024;
    localparam int VALUE_BITS    = 32;

    localparam int ENT_AW    = $clog2(ENTITY_LIMIT);
    localparam int SLOT_AW   = $clog2(SLOT_CAPACITY);
    localparam int COUNT_W   = $clog2(SLOT_CAPACITY + 1);
    localparam int MASK_W    = 64;
    localparam int CFG_IDX_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLED = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MASK    = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_LOOKUP = 2'd2,
        MODE_READ   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_ABSENT = 2'd1,
        STATUS_DUP    = 2'd2,
        STATUS_FULL   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CHANGE_NONE    = 2'd0,
        CHANGE_ADDED   = 2'd1,
        CHANGE_REMOVED = 2'd2
    } change_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_FETCH,
        ST_MOVE1,
        ST_MOVE2,
        ST_FINAL,
        ST_RESP
    } state_t;

    typedef struct packed {
        mode_t        mode;
        logic [9:0]   entity;
        logic [9:0]   slot;
        logic [31:0]  value_in;
        logic [63:0]  entity_mask;
    } in_item_t;

    typedef struct packed {
        status_t      status;
        logic         present;
        logic [31:0]  value_out;
        logic [9:0]   entity_out;
        logic [9:0]   slot_out;
        logic         in_matched;
        logic [10:0]  entry_count;
        logic [10:0]  matched_count;
        change_t      membership_change;
    } out_item_t;

    // Entity memory word: valid flag and packed slot.
    typedef struct packed {
        logic               valid;
        logic [SLOT_AW-1:0] slot;
    } ent_word_t;

    // Slot memory word: owning entity and stored value.
    typedef struct packed {
        logic [ENT_AW-1:0]     owner;
        logic [VALUE_BITS-1:0] value;
    } slot_word_t;

endpackage

FILE: hw/rtl/partitioned_sparse_set_table_unit.sv
// Partitioned sparse-set table: maps entity numbers to packed value slots.
// Depends on psst_pkg and partitioned_sparse_set_table_unit_defines.svh.
//
// Items arrive on s_valid/s_ready/s_data and results leave on
// m_valid/m_ready/m_data, one result item for each input item, in order.
// cfg_valid/cfg_ready/cfg_index/cfg_data writes filter_enabled (index 0)
// and filter_mask (index 1); cfg_ready is always high. Write the filter
// only while the table is idle, normally while it is still empty.
// One item is worked on at a time by a sequencer around two memories with a
// registered read: an entity memory (valid bit and slot) and a slot memory
// (owner and value). Each memory access costs one state. Every item passes
// LOOK and ends in RESP; between them a lookup or a duplicate add uses FETCH,
// a plain add FINAL, a matched add that moves the first unmatched entry to
// the end MOVE2 and FINAL, and a remove FETCH, up to two move states (one per
// entry moved to keep the front packed) and FINAL; a slot read or a failed
// request uses none. The result item turns valid in the same cycle as the
// next item can be accepted. After reset the entity memory is swept clear,
// one entry per cycle, with s_ready low; cfg writes are taken meanwhile. The
// next item is accepted while a result waits in the output register; if the
// receiver stalls, the sequencer holds the newer result until it is free.
`include "partitioned_sparse_set_table_unit_defines.svh"

module partitioned_sparse_set_table_unit
    import psst_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MASK_W-1:0]    cfg_data
);

    // Sequencer and bookkeeping registers.
    state_t              state_reg, state_next;
    logic [COUNT_W-1:0]  held_reg, held_next;
    logic [COUNT_W-1:0]  front_reg, front_next;
    logic [ENT_AW-1:0]   clr_idx_reg, clr_idx_next;
    in_item_t            req_reg, req_next;
    logic [SLOT_AW-1:0]  pos_reg, pos_next;
    logic [SLOT_AW-1:0]  mv_dst_reg, mv_dst_next;
    logic                front_hit_reg, front_hit_next;
    out_item_t           res_reg, res_next;
    logic                m_valid_reg, m_valid_next;
    out_item_t           m_data_reg, m_data_next;
    logic                filter_en_reg;
    logic [MASK_W-1:0]   filter_mask_reg;

    // Memory ports.
    ent_word_t           ent_mem [ENTITY_LIMIT];
    ent_word_t           ent_rdata_reg;
    logic                ent_we;
    logic [ENT_AW-1:0]   ent_waddr, ent_raddr;
    ent_word_t           ent_wdata;
    slot_word_t          slot_mem [SLOT_CAPACITY];
    slot_word_t          slot_rdata_reg;
    logic                slot_we;
    logic [SLOT_AW-1:0]  slot_waddr, slot_raddr;
    slot_word_t          slot_wdata;

    // Decisions shared by the control blocks.
    logic                known, has, full, add_match, front_lt_held;
    logic                pos_front, pos_ne_m, last_ne_m, pos_ne_last, out_free;
    logic                read_hit;
    logic [SLOT_AW-1:0]  look_pos, front_slot, held_slot, m_slot, last_slot;
    logic [VALUE_BITS-1:0] req_value;

    assign known         = (32'(req_reg.entity) < ENTITY_LIMIT);
    assign has           = known && ent_rdata_reg.valid;
    assign look_pos      = ent_rdata_reg.slot;
    assign full          = (held_reg >= COUNT_W'(SLOT_CAPACITY));
    assign add_match     = filter_en_reg
                           && ((req_reg.entity_mask & filter_mask_reg) == filter_mask_reg);
    assign front_lt_held = (front_reg < held_reg);
    assign front_slot    = SLOT_AW'(front_reg);
    assign held_slot     = SLOT_AW'(held_reg);
    assign m_slot        = SLOT_AW'(front_reg - 1'b1);
    assign last_slot     = SLOT_AW'(held_reg - 1'b1);
    assign pos_front     = (COUNT_W'(pos_reg) < front_reg);
    assign pos_ne_m      = (pos_reg != m_slot);
    assign last_ne_m     = (last_slot != m_slot);
    assign pos_ne_last   = (pos_reg != last_slot);
    assign read_hit      = ({1'b0, req_reg.slot} < held_reg);
    assign out_free      = !m_valid_reg || m_ready;
    assign req_value     = req_reg.value_in[VALUE_BITS-1:0];

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_idx_reg == ENT_AW'(ENTITY_LIMIT - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) state_next = ST_LOOK;
            end
            ST_LOOK: begin
                unique case (req_reg.mode)
                    MODE_READ: state_next = ST_RESP;
                    MODE_LOOKUP, MODE_REMOVE: state_next = has ? ST_FETCH : ST_RESP;
                    MODE_ADD: begin
                        priority if (!known) state_next = ST_RESP;
                        else if (has) state_next = ST_FETCH;
                        else if (full) state_next = ST_RESP;
                        else if (add_match && front_lt_held) state_next = ST_MOVE2;
                        else state_next = ST_FINAL;
                    end
                endcase
            end
            ST_FETCH: begin
                if (req_reg.mode == MODE_REMOVE) begin
                    priority if (pos_front && pos_ne_m) state_next = ST_MOVE1;
                    else if (pos_front && last_ne_m) state_next = ST_MOVE2;
                    else if (!pos_front && pos_ne_last) state_next = ST_MOVE2;
                    else state_next = ST_FINAL;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_MOVE1: state_next = last_ne_m ? ST_MOVE2 : ST_FINAL;
            ST_MOVE2: state_next = ST_FINAL;
            ST_FINAL: state_next = ST_RESP;
            ST_RESP: begin
                if (out_free) state_next = ST_IDLE;
            end
        endcase
    end

    // Memory controls. Reads are issued one state ahead of their use.
    always_comb begin
        ent_we     = 1'b0;
        ent_waddr  = '0;
        ent_wdata  = '0;
        ent_raddr  = s_data.entity[ENT_AW-1:0];
        slot_we    = 1'b0;
        slot_waddr = '0;
        slot_wdata = '0;
        slot_raddr = s_data.slot[SLOT_AW-1:0];
        unique case (state_reg)
            ST_CLEAR: begin
                ent_we    = 1'b1;
                ent_waddr = clr_idx_reg;
            end
            ST_LOOK: begin
                // Own entry for lookup, remove and duplicate add; otherwise
                // the first unmatched entry that a matched add displaces.
                slot_raddr = has ? look_pos : front_slot;
            end
            ST_FETCH: begin
                slot_raddr = (pos_front && pos_ne_m) ? m_slot : last_slot;
            end
            ST_MOVE1: begin
                // Last matched entry fills the hole; then fetch the last entry.
                slot_we    = 1'b1;
                slot_waddr = pos_reg;
                slot_wdata = slot_rdata_reg;
                ent_we     = 1'b1;
                ent_waddr  = slot_rdata_reg.owner;
                ent_wdata  = '{valid: 1'b1, slot: pos_reg};
                slot_raddr = last_slot;
            end
            ST_MOVE2: begin
                slot_we    = 1'b1;
                slot_waddr = mv_dst_reg;
                slot_wdata = slot_rdata_reg;
                ent_we     = 1'b1;
                ent_waddr  = slot_rdata_reg.owner;
                ent_wdata  = '{valid: 1'b1, slot: mv_dst_reg};
            end
            ST_FINAL: begin
                ent_we    = 1'b1;
                ent_waddr = req_reg.entity[ENT_AW-1:0];
                if (req_reg.mode == MODE_ADD) begin
                    ent_wdata  = '{valid: 1'b1, slot: pos_reg};
                    slot_we    = 1'b1;
                    slot_waddr = pos_reg;
                    slot_wdata = '{owner: req_reg.entity[ENT_AW-1:0], value: req_value};
                end
            end
            ST_IDLE, ST_RESP: begin
            end
        endcase
    end

    // Datapath next values.
    always_comb begin
        held_next      = held_reg;
        front_next     = front_reg;
        clr_idx_next   = clr_idx_reg;
        req_next       = req_reg;
        pos_next       = pos_reg;
        mv_dst_next    = mv_dst_reg;
        front_hit_next = front_hit_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        unique case (state_reg)
            ST_CLEAR: clr_idx_next = clr_idx_reg + 1'b1;
            ST_IDLE: begin
                if (s_valid) req_next = s_data;
            end
            ST_LOOK: begin
                pos_next       = has ? look_pos : (add_match ? front_slot : held_slot);
                mv_dst_next    = held_slot;
                front_hit_next = add_match;
                // Failed request unless a later state fills in the entry.
                res_next                   = '0;
                res_next.status            = STATUS_ABSENT;
                res_next.entity_out        = req_reg.entity;
                res_next.membership_change = CHANGE_NONE;
                if (req_reg.mode == MODE_READ) begin
                    if (read_hit) begin
                        res_next.status     = STATUS_OK;
                        res_next.present    = 1'b1;
                        res_next.value_out  = 32'(slot_rdata_reg.value);
                        res_next.entity_out = 10'(slot_rdata_reg.owner);
                        res_next.slot_out   = req_reg.slot;
                        res_next.in_matched = ({1'b0, req_reg.slot} < front_reg);
                    end else begin
                        res_next.entity_out = '0;
                    end
                end else if (req_reg.mode == MODE_ADD && known && !has && full) begin
                    res_next.status = STATUS_FULL;
                end
            end
            ST_FETCH: begin
                mv_dst_next               = pos_front ? m_slot : pos_reg;
                front_hit_next            = pos_front;
                res_next.status           = (req_reg.mode == MODE_ADD) ? STATUS_DUP : STATUS_OK;
                res_next.present          = (req_reg.mode != MODE_REMOVE);
                res_next.value_out        = 32'(slot_rdata_reg.value);
                res_next.entity_out       = req_reg.entity;
                res_next.slot_out         = 10'(pos_reg);
                res_next.in_matched       = pos_front;
                res_next.membership_change =
                    (req_reg.mode == MODE_REMOVE) ? CHANGE_REMOVED : CHANGE_NONE;
            end
            ST_FINAL: begin
                if (req_reg.mode == MODE_ADD) begin
                    held_next  = held_reg + 1'b1;
                    front_next = front_reg + COUNT_W'(front_hit_reg);
                    res_next.status            = STATUS_OK;
                    res_next.present           = 1'b1;
                    res_next.value_out         = 32'(req_value);
                    res_next.entity_out        = req_reg.entity;
                    res_next.slot_out          = 10'(pos_reg);
                    res_next.in_matched        = front_hit_reg;
                    res_next.membership_change = CHANGE_ADDED;
                end else begin
                    held_next  = held_reg - 1'b1;
                    front_next = front_reg - COUNT_W'(front_hit_reg);
                end
            end
            ST_MOVE1, ST_MOVE2, ST_RESP: begin
            end
        endcase

        // Output register: load a finished result once it is free.
        if (state_reg == ST_RESP && out_free) begin
            m_valid_next              = 1'b1;
            m_data_next               = res_reg;
            m_data_next.entry_count   = held_reg;
            m_data_next.matched_count = front_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            held_reg        <= '0;
            front_reg       <= '0;
            clr_idx_reg     <= '0;
            m_valid_reg     <= 1'b0;
            filter_en_reg   <= 1'b0;
            filter_mask_reg <= '0;
        end else begin
            state_reg   <= state_next;
            held_reg    <= held_next;
            front_reg   <= front_next;
            clr_idx_reg <= clr_idx_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_FILTER_ENABLED) filter_en_reg <= cfg_data[0];
                if (cfg_index == CFG_FILTER_MASK) filter_mask_reg <= cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        pos_reg       <= pos_next;
        mv_dst_reg    <= mv_dst_next;
        front_hit_reg <= front_hit_next;
        res_reg       <= res_next;
        m_data_reg    <= m_data_next;
    end

    // Entity memory.
    always_ff @(posedge aclk) begin
        if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
        ent_rdata_reg <= ent_mem[ent_raddr];
    end

    // Slot memory.
    always_ff @(posedge aclk) begin
        if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
        slot_rdata_reg <= slot_mem[slot_raddr];
    end

    `PSST_ASSERT(a_front_le_held, aclk, aresetn, front_reg <= held_reg)
    `PSST_ASSERT(a_held_le_cap, aclk, aresetn, held_reg <= COUNT_W'(SLOT_CAPACITY))
    `PSST_ASSERT(a_counts_only_final, aclk, aresetn, (state_reg != ST_FINAL) |=> $stable(held_reg))
    `PSST_ASSERT_RST(a_reset_sweeps, aclk, !aresetn |=> (state_reg == ST_CLEAR))

endmodule

FILE: dv/tb_partitioned_sparse_set_table_unit.sv
// Self-checking testbench for partitioned_sparse_set_table_unit.
// Needs psst_pkg and the unit's RTL; a built-in predictor checks every result
// item while random idling stresses both valid/ready channels.
`timescale 1ns / 1ps

module tb_partitioned_sparse_set_table_unit
    import psst_pkg::*;
();

    localparam int HALF_PERIOD   = 6;
    localparam int STALL_LIMIT   = 4000;  // covers the clearing sweep after reset
    localparam int SETTLE_CYCLES = 16;    // longer than the slowest remove
    localparam int TAIL_CYCLES   = 32;
    localparam int PHASE_ITEMS   = 55;

    typedef enum logic [1:0] {
        JOB_ITEM,
        JOB_WRITE,
        JOB_SETTLE
    } job_kind_t;

    typedef struct {
        job_kind_t              kind;
        in_item_t               item;
        logic [CFG_IDX_W-1:0]   idx;
        logic [MASK_W-1:0]      data;
        bit                     steady;
    } job_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_item_t             s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_item_t            m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [MASK_W-1:0]    cfg_data = '0;

    partitioned_sparse_set_table_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predicted table contents. These mirror the sparse set as the unit
    // should hold it: a presence flag and slot per entity, an owner and a
    // value per packed slot, the entry count and the size of the matched
    // front region, plus the two filter registers.
    // ------------------------------------------------------------------
    bit                    entity_held [ENTITY_LIMIT];
    logic [SLOT_AW-1:0]    slot_of     [ENTITY_LIMIT];
    logic [ENT_AW-1:0]     owner_of    [SLOT_CAPACITY];
    logic [VALUE_BITS-1:0] value_of    [SLOT_CAPACITY];
    int unsigned           held_total = 0;
    int unsigned           front_total = 0;
    bit                    filter_on = 1'b0;
    logic [MASK_W-1:0]     filter_bits = '0;

    // Result items predicted for accepted items, oldest first.
    out_item_t replies_due[$];

    // Items and register writes still to be sent, filled once at time zero.
    job_t stim_jobs[$];

    int mismatches = 0;

    // Moves the entry in slot src to slot dst and repoints its entity.
    function automatic void shift_entry(int unsigned src, int unsigned dst);
        logic [ENT_AW-1:0] owner;
        owner = owner_of[src];
        value_of[dst] = value_of[src];
        owner_of[dst] = owner;
        slot_of[owner] = SLOT_AW'(dst);
    endfunction

    // Applies one item to the predicted table and returns the result item.
    function automatic out_item_t table_op(in_item_t it);
        out_item_t   r;
        int unsigned pos, dst, m, last;
        bit          hit, match;
        r = '0;
        r.status = STATUS_OK;
        r.membership_change = CHANGE_NONE;
        r.entity_out = it.entity;
        hit = entity_held[it.entity];
        pos = hit ? slot_of[it.entity] : 0;
        case (it.mode)
            MODE_ADD: begin
                if (hit) begin
                    // A duplicate add reports the existing entry untouched.
                    r.status = STATUS_DUP;
                    r.present = 1'b1;
                    r.value_out = value_of[pos];
                    r.slot_out = SLOT_AW'(pos);
                    r.in_matched = pos < front_total;
                end else if (held_total >= SLOT_CAPACITY) begin
                    r.status = STATUS_FULL;
                end else begin
                    match = filter_on && ((it.entity_mask & filter_bits) == filter_bits);
                    dst = held_total;
                    if (match) begin
                        // The first unmatched entry, if any, goes to the end.
                        if (front_total < held_total) shift_entry(front_total, held_total);
                        dst = front_total;
                        front_total++;
                    end
                    value_of[dst] = it.value_in;
                    owner_of[dst] = it.entity;
                    slot_of[it.entity] = SLOT_AW'(dst);
                    entity_held[it.entity] = 1'b1;
                    held_total++;
                    r.present = 1'b1;
                    r.value_out = it.value_in;
                    r.slot_out = SLOT_AW'(dst);
                    r.in_matched = match;
                    r.membership_change = CHANGE_ADDED;
                end
            end
            MODE_REMOVE: begin
                if (!hit) begin
                    r.status = STATUS_ABSENT;
                end else begin
                    r.value_out = value_of[pos];
                    r.slot_out = SLOT_AW'(pos);
                    r.in_matched = pos < front_total;
                    last = held_total - 1;
                    if (pos < front_total) begin
                        // Last matched entry fills the hole, last entry fills its place.
                        m = front_total - 1;
                        if (pos != m) shift_entry(m, pos);
                        if (last != m) shift_entry(last, m);
                        front_total--;
                    end else if (pos != last) begin
                        shift_entry(last, pos);
                    end
                    held_total--;
                    entity_held[it.entity] = 1'b0;
                    r.membership_change = CHANGE_REMOVED;
                end
            end
            MODE_LOOKUP: begin
                if (!hit) begin
                    r.status = STATUS_ABSENT;
                end else begin
                    r.present = 1'b1;
                    r.value_out = value_of[pos];
                    r.slot_out = SLOT_AW'(pos);
                    r.in_matched = pos < front_total;
                end
            end
            default: begin
                if (it.slot >= held_total) begin
                    r.status = STATUS_ABSENT;
                    r.entity_out = '0;
                end else begin
                    r.present = 1'b1;
                    r.value_out = value_of[it.slot];
                    r.entity_out = owner_of[it.slot];
                    r.slot_out = it.slot;
                    r.in_matched = it.slot < front_total;
                end
            end
        endcase
        r.entry_count = 11'(held_total);
        r.matched_count = 11'(front_total);
        return r;
    endfunction

    function automatic void write_reg(logic [CFG_IDX_W-1:0] idx, logic [MASK_W-1:0] data);
        if (idx == CFG_FILTER_ENABLED) filter_on = data[0];
        else if (idx == CFG_FILTER_MASK) filter_bits = data;
    endfunction

    function automatic string fmt_reply(out_item_t r);
        return $sformatf({"status=%0d present=%0d value=%h entity=%0d slot=%0d ",
                          "matched=%0d count=%0d front=%0d change=%0d"},
                         r.status, r.present, r.value_out, r.entity_out, r.slot_out,
                         r.in_matched, r.entry_count, r.matched_count,
                         r.membership_change);
    endfunction

    // Mostly no gap, sometimes a few cycles, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building. The builder keeps its own list of live entities
    // so that removes and lookups mostly hit entries that exist and slot
    // reads mostly fall inside the packed range.
    // ------------------------------------------------------------------
    bit live_bit[ENTITY_LIMIT];
    int live[$];
    bit build_steady = 1'b0;

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // A filter with one to three component bits, so random masks match often.
    function automatic logic [63:0] few_bits();
        logic [63:0] m;
        int          n;
        m = '0;
        n = $urandom_range(1, 3);
        repeat (n) m[$urandom_range(0, 63)] = 1'b1;
        return m;
    endfunction

    task automatic push_item(mode_t md, int ent, int slot, logic [31:0] v, logic [63:0] em);
        job_t j;
        int   k;
        j.kind = JOB_ITEM;
        j.item.mode = md;
        j.item.entity = 10'(ent);
        j.item.slot = 10'(slot);
        j.item.value_in = v;
        j.item.entity_mask = em;
        j.idx = '0;
        j.data = '0;
        j.steady = build_steady;
        stim_jobs.insert(stim_jobs.size(), j);
        if (md == MODE_ADD && !live_bit[ent]) begin
            live_bit[ent] = 1'b1;
            live.insert(live.size(), ent);
        end else if (md == MODE_REMOVE && live_bit[ent]) begin
            live_bit[ent] = 1'b0;
            for (k = 0; k < live.size(); k++) begin
                if (live[k] == ent) begin
                    live.delete(k);
                    break;
                end
            end
        end
    endtask

    // The sender holds off until every predicted result has come back.
    task automatic push_settle();
        job_t j;
        j.kind = JOB_SETTLE;
        j.item = '0;
        j.idx = '0;
        j.data = '0;
        j.steady = build_steady;
        stim_jobs.insert(stim_jobs.size(), j);
    endtask

    // Register writes only ever follow a settle, so the table is idle.
    task automatic push_write(logic [CFG_IDX_W-1:0] idx, logic [MASK_W-1:0] data);
        job_t j;
        push_settle();
        j.kind = JOB_WRITE;
        j.item = '0;
        j.idx = idx;
        j.data = data;
        j.steady = build_steady;
        stim_jobs.insert(stim_jobs.size(), j);
    endtask

    task automatic drain_table();
        int k;
        while (live.size() > 0) begin
            k = $urandom_range(0, live.size() - 1);
            push_item(MODE_REMOVE, live[k], $urandom_range(0, 1023), $urandom, rnd64());
        end
    endtask

    // One random item. Entities come mostly from a small pool so that
    // duplicate adds and hits are common; about half the entity masks
    // are built to satisfy the current filter.
    task automatic push_random_op(logic [63:0] fmask);
        int          r, k, ent, slot, n;
        logic [63:0] em;
        r = $urandom_range(0, 99);
        ent = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 47);
        n = live.size();
        em = $urandom_range(0, 1) ? (fmask | rnd64()) : rnd64();
        slot = $urandom_range(0, 1023);
        if (r < 40) begin
            push_item(MODE_ADD, ent, slot, $urandom, em);
        end else if (r < 80) begin
            if (n > 0 && $urandom_range(0, 4) != 0) ent = live[$urandom_range(0, n - 1)];
            push_item((r < 65) ? MODE_REMOVE : MODE_LOOKUP, ent, slot, $urandom, em);
        end else begin
            k = $urandom_range(0, 9);
            if (n > 0 && k < 7) slot = $urandom_range(0, n - 1);
            else if (k < 9) slot = n + $urandom_range(0, 2);
            push_item(MODE_READ, ent, slot, $urandom, em);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver. At each rising edge it first records what was accepted at
    // that edge (predicting the result of an accepted item), then decides
    // what to present next. Valid stays up untouched while an item waits.
    // ------------------------------------------------------------------
    int gap_left = 0;
    int settle_count = 0;
    bit drive_steady = 1'b0;

    always @(posedge aclk) begin : driver
        bit   item_taken, write_taken, busy, next_s, next_c;
        job_t j;
        item_taken = s_valid && s_ready;
        write_taken = cfg_valid && cfg_ready;
        if (!aresetn) begin
            s_valid <= 1'b0;
            cfg_valid <= 1'b0;
        end else begin
            if (item_taken) replies_due.insert(replies_due.size(), table_op(s_data));
            if (write_taken) write_reg(cfg_index, cfg_data);
            if (item_taken || write_taken) gap_left = drive_steady ? 0 : pick_gap();
            busy = (s_valid && !item_taken) || (cfg_valid && !write_taken);
            if (!busy) begin
                next_s = 1'b0;
                next_c = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (stim_jobs.size() > 0) begin
                    case (stim_jobs[0].kind)
                        JOB_ITEM: begin
                            j = stim_jobs.pop_front();
                            s_data <= j.item;
                            drive_steady = j.steady;
                            next_s = 1'b1;
                        end
                        JOB_WRITE: begin
                            j = stim_jobs.pop_front();
                            cfg_index <= j.idx;
                            cfg_data <= j.data;
                            drive_steady = j.steady;
                            next_c = 1'b1;
                        end
                        default: begin
                            // Wait for the last result, then give the unit
                            // time to finish any entry moves still going on.
                            if (replies_due.size() != 0) begin
                                settle_count = 0;
                            end else if (settle_count < SETTLE_CYCLES) begin
                                settle_count++;
                            end else begin
                                settle_count = 0;
                                void'(stim_jobs.pop_front());
                            end
                        end
                    endcase
                end
                s_valid <= next_s;
                cfg_valid <= next_c;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor. Each accepted result item is compared field by field with
    // the oldest prediction. Ready stalls at random, with occasional long
    // stretches where it never drops.
    // ------------------------------------------------------------------
    int stall_left = 0;
    int calm_left = 0;

    always @(posedge aclk) begin : monitor
        out_item_t want;
        bit        bad;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (replies_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result item with nothing expected: %s", fmt_reply(m_data));
                end else begin
                    want = replies_due.pop_front();
                    bad = (m_data.status !== want.status)
                       || (m_data.present !== want.present)
                       || (m_data.value_out !== want.value_out)
                       || (m_data.entity_out !== want.entity_out)
                       || (m_data.slot_out !== want.slot_out)
                       || (m_data.in_matched !== want.in_matched)
                       || (m_data.entry_count !== want.entry_count)
                       || (m_data.matched_count !== want.matched_count)
                       || (m_data.membership_change !== want.membership_change);
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch at %0t", $realtime);
                            $display("  expected: %s", fmt_reply(want));
                            $display("  actual:   %s", fmt_reply(m_data));
                        end
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (calm_left > 0) calm_left--;
                else if ($urandom_range(0, 99) < 2) calm_left = 150;
                else stall_left = pick_gap();
            end
        end
    end

    // Watchdog: ends the run if no channel moves anything for too long.
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial begin
        int          p, i;
        bit          en;
        logic [63:0] fmask;

        // Directed part, filter off: empty table, field extremes, a
        // duplicate add, reads inside and beyond the packed range, and a
        // remove of an entity that is already gone.
        push_write(CFG_FILTER_ENABLED, 64'd0);
        push_write(CFG_FILTER_MASK, '1);
        push_item(MODE_READ, 0, 0, $urandom, rnd64());
        push_item(MODE_LOOKUP, 0, 1023, $urandom, rnd64());
        push_item(MODE_REMOVE, 1023, 0, $urandom, rnd64());
        push_item(MODE_ADD, 0, 0, 32'h0000_0000, 64'h0);
        push_item(MODE_ADD, 1023, 1023, 32'hFFFF_FFFF, '1);
        push_item(MODE_ADD, 0, 5, 32'h1234_5678, '1);
        push_item(MODE_LOOKUP, 1023, 0, $urandom, rnd64());
        push_item(MODE_READ, 0, 1, $urandom, rnd64());
        push_item(MODE_READ, 0, 2, $urandom, rnd64());
        push_item(MODE_READ, 0, 1023, $urandom, rnd64());
        push_item(MODE_REMOVE, 0, 0, $urandom, rnd64());
        push_item(MODE_REMOVE, 0, 0, $urandom, rnd64());
        push_item(MODE_REMOVE, 1023, 0, $urandom, rnd64());

        // Filter on with the table empty. Two matched adds while no
        // unmatched entry exists, then an unmatched one that a later
        // matched add pushes to the end. The removes fill a matched hole
        // and then take out the last matched slot.
        push_write(CFG_FILTER_ENABLED, 64'd1);
        push_write(CFG_FILTER_MASK, 64'h8000_0000_0000_0001);
        push_item(MODE_ADD, 5, 0, $urandom, '1);
        push_item(MODE_ADD, 6, 0, $urandom, '1);
        push_item(MODE_ADD, 7, 0, $urandom, 64'h0000_0000_0000_0001);
        push_item(MODE_ADD, 8, 0, $urandom, 64'h8000_0000_0000_0001);
        push_item(MODE_REMOVE, 5, 0, $urandom, rnd64());
        push_item(MODE_REMOVE, 6, 0, $urandom, rnd64());
        push_item(MODE_READ, 0, 0, $urandom, rnd64());
        push_item(MODE_READ, 0, 1, $urandom, rnd64());

        // Filter switched off while entries are held: nothing is reordered
        // and a fully matching add still lands at the end.
        push_write(CFG_FILTER_ENABLED, 64'd0);
        push_item(MODE_ADD, 9, 0, $urandom, '1);
        push_item(MODE_LOOKUP, 9, 0, $urandom, rnd64());

        // Random phases, each under its own filter setting. Most start
        // from an empty table; one changes the filter with entries held.
        for (p = 0; p < 6; p++) begin
            case (p)
                0: begin en = 1'b1; fmask = '0; end
                1: begin en = 1'b1; fmask = '1; end
                2: begin en = 1'b1; fmask = few_bits(); end
                3: begin en = 1'b0; fmask = rnd64(); end
                4: begin en = 1'b1; fmask = few_bits(); end
                default: begin en = 1'b1; fmask = rnd64(); end
            endcase
            build_steady = (p == 2);
            if (p != 4) drain_table();
            push_write(CFG_FILTER_ENABLED, 64'(en));
            push_write(CFG_FILTER_MASK, fmask);
            for (i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 1 && i == PHASE_ITEMS / 2) push_settle();
                push_random_op(en ? fmask : rnd64());
            end
        end
        build_steady = 1'b0;
        drain_table();

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (stim_jobs.size() != 0 || s_valid || cfg_valid || replies_due.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatches == 0 && replies_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
